// ----- sv/tanfp_pkg.sv -----
`default_nettype none

package tanfp_pkg;

    localparam int ANGLE_FRAC_BITS = 32;
    localparam int SERIES_TERMS    = 7;
    localparam int SER_STEPS       = SERIES_TERMS - 1;

    localparam logic [63:0] TWO_OVER_PI = 64'hA2F9_836E_4E44_152A;
    localparam logic [63:0] HALF_PI_HI  = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] HALF_PI_LO  = 64'h6263_3145_C06E_0E68;
    localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;

    // Maclaurin coefficients of tan, terms 1..6: num/den
    localparam logic [15:0] SER_NUM [6] = '{16'd1, 16'd2, 16'd17, 16'd62, 16'd1382, 16'd21844};
    localparam logic [22:0] SER_DEN [6] = '{23'd3, 23'd15, 23'd315, 23'd2835, 23'd155925,
                                            23'd6081075};
    // floor(2^64/den); quotient estimate is exact or one low
    localparam logic [63:0] SER_RCP [6] = '{
        64'((65'd1 << 64) / 65'd3),
        64'((65'd1 << 64) / 65'd15),
        64'((65'd1 << 64) / 65'd315),
        64'((65'd1 << 64) / 65'd2835),
        64'((65'd1 << 64) / 65'd155925),
        64'((65'd1 << 64) / 65'd6081075)
    };

    typedef struct packed {
        logic        neg;
        logic        odd;
        logic        sr;
        logic [47:0] m;
        logic [63:0] u2;
        logic [63:0] term;
        logic [63:0] res;
        logic [63:0] aux;
    } t_ctx;

    // unsigned Q62 product, rounded half up
    function automatic logic [63:0] q62_round(input logic [127:0] p);
        logic [127:0] s;
        s = p + (128'd1 << 61);
        return s[125:62];
    endfunction

endpackage

`default_nettype wire

// ----- sv/tanfp_mul.sv -----
`default_nettype none

// 64x64 unsigned multiplier, two stages: 32x32 partial products, then sum.
// Carries a valid bit and the request context alongside.
module tanfp_mul import tanfp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  t_ctx         i_ctx,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_vld,
    output t_ctx         o_ctx,
    output logic [127:0] o_prod
);

    logic         r_vld1;
    logic         r_vld2;
    t_ctx         r_ctx1;
    t_ctx         r_ctx2;
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic [127:0] r_prod;
    logic [127:0] n_prod;

    always_comb begin
        n_prod = {64'd0, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0} + {r_hh, 64'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll   <= {32'd0, i_a[31:0]}  * {32'd0, i_b[31:0]};
            r_lh   <= {32'd0, i_a[31:0]}  * {32'd0, i_b[63:32]};
            r_hl   <= {32'd0, i_a[63:32]} * {32'd0, i_b[31:0]};
            r_hh   <= {32'd0, i_a[63:32]} * {32'd0, i_b[63:32]};
            r_ctx1 <= i_ctx;
            r_ctx2 <= r_ctx1;
            r_prod <= n_prod;
        end
    end

    assign o_vld  = r_vld2;
    assign o_ctx  = r_ctx2;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- sv/tangent_fixed_point_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake          Payload
// angle     in         i_valid / o_ready  i_angle (Q15.32, signed)
// tangent   out        o_valid / i_ready  o_tangent (Q31.32, signed), o_saturated
//
// One request per cycle while no result is held in the output register; the pipeline
// holds the 64 one-bit stages of the restoring divider plus the six series steps of eight stages each.
// Reset (synchronous, active low) clears all valid bits; data registers hold.
// The whole pipeline advances together; when a result sits unaccepted in the
// output register, every stage freezes and o_ready drops.
module tangent_fixed_point_unit import tanfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [47:0] i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_tangent,
    output logic               o_saturated
);

    localparam int DIV_STEPS = 64;
    localparam int NW        = 64 + ANGLE_FRAC_BITS + 1;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        neg_res;
        logic        odd;
        logic        neg;
        logic        zero;
        logic        ovf;
        logic [63:0] d;
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] q;
    } t_dvs;

    logic w_adv;

    // ---------------- magnitude ----------------
    logic r_s1_vld;
    t_ctx r_s1_ctx;
    t_ctx n_s1_ctx;

    always_comb begin
        n_s1_ctx     = '0;
        n_s1_ctx.neg = i_angle[47];
        n_s1_ctx.m   = i_angle[47] ? (~$unsigned(i_angle) + 48'd1) : $unsigned(i_angle);
    end

    // ---------------- k = round(m * 2/pi) ----------------
    logic         w_m0_vld;
    t_ctx         w_m0_ctx;
    logic [127:0] w_m0_prod;

    tanfp_mul u_mul_k (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_vld  (r_s1_vld), .i_ctx(r_s1_ctx),
        .i_a    ({16'd0, r_s1_ctx.m}), .i_b(TWO_OVER_PI),
        .o_vld  (w_m0_vld), .o_ctx(w_m0_ctx), .o_prod(w_m0_prod)
    );

    logic        r_s4_vld;
    t_ctx        r_s4_ctx;
    t_ctx        n_s4_ctx;
    logic [63:0] n_k;

    always_comb begin
        n_k          = (w_m0_prod[127:64] + (64'd1 << (ANGLE_FRAC_BITS - 1)))
                       >> ANGLE_FRAC_BITS;
        n_s4_ctx     = w_m0_ctx;
        n_s4_ctx.aux = n_k;
        n_s4_ctx.odd = n_k[0];
    end

    // ---------------- k * pi/2, two pieces ----------------
    logic         w_m1_vld;
    t_ctx         w_m1_ctx;
    logic [127:0] w_m1_prod;
    t_ctx         n_m2_ctx;

    tanfp_mul u_mul_hi (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_vld  (r_s4_vld), .i_ctx(r_s4_ctx),
        .i_a    (r_s4_ctx.aux), .i_b(HALF_PI_HI),
        .o_vld  (w_m1_vld), .o_ctx(w_m1_ctx), .o_prod(w_m1_prod)
    );

    always_comb begin
        n_m2_ctx      = w_m1_ctx;
        n_m2_ctx.term = w_m1_prod[127:64];
        n_m2_ctx.res  = w_m1_prod[63:0];
    end

    logic         w_m2_vld;
    t_ctx         w_m2_ctx;
    logic [127:0] w_m2_prod;

    tanfp_mul u_mul_lo (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_vld  (w_m1_vld), .i_ctx(n_m2_ctx),
        .i_a    (w_m1_ctx.aux), .i_b(HALF_PI_LO),
        .o_vld  (w_m2_vld), .o_ctx(w_m2_ctx), .o_prod(w_m2_prod)
    );

    logic         r_s9_vld;
    t_ctx         r_s9_ctx;
    logic [127:0] r_s9_sum;
    logic [127:0] n_s9_sum;

    // low piece rounded to Q62 before it joins the high piece
    always_comb begin
        n_s9_sum = {w_m2_ctx.term, w_m2_ctx.res} + ((w_m2_prod + (128'd1 << 63)) >> 64);
    end

    // ---------------- r = m - k*pi/2, u = |r|/2 ----------------
    logic         r_s10_vld;
    t_ctx         r_s10_ctx;
    t_ctx         n_s10_ctx;
    logic [127:0] n_diff;
    logic [63:0]  n_abs;

    always_comb begin
        n_diff         = ({80'd0, r_s9_ctx.m} << (62 - ANGLE_FRAC_BITS)) - r_s9_sum;
        n_abs          = n_diff[127] ? (64'd0 - n_diff[63:0]) : n_diff[63:0];
        n_s10_ctx      = r_s9_ctx;
        n_s10_ctx.sr   = n_diff[127];
        n_s10_ctx.term = n_abs >> 1;
        n_s10_ctx.res  = n_abs >> 1;
    end

    logic         w_mu_vld;
    t_ctx         w_mu_ctx;
    logic [127:0] w_mu_prod;

    tanfp_mul u_mul_u2 (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_vld  (r_s10_vld), .i_ctx(r_s10_ctx),
        .i_a    (r_s10_ctx.term), .i_b(r_s10_ctx.term),
        .o_vld  (w_mu_vld), .o_ctx(w_mu_ctx), .o_prod(w_mu_prod)
    );

    logic r_s13_vld;
    t_ctx r_s13_ctx;
    t_ctx n_s13_ctx;

    always_comb begin
        n_s13_ctx    = w_mu_ctx;
        n_s13_ctx.u2 = q62_round(w_mu_prod);
    end

    // ---------------- series steps ----------------
    logic w_blk_vld [SER_STEPS+1];
    t_ctx w_blk_ctx [SER_STEPS+1];

    assign w_blk_vld[0] = r_s13_vld;
    assign w_blk_ctx[0] = r_s13_ctx;

    for (genvar g = 0; g < SER_STEPS; g++) begin : g_ser
        logic         w_a_vld;
        t_ctx         w_a_ctx;
        logic [127:0] w_a_prod;
        logic         r_rd_vld;
        t_ctx         r_rd_ctx;
        t_ctx         n_rd_ctx;
        logic         r_nm_vld;
        t_ctx         r_nm_ctx;
        t_ctx         n_nm_ctx;
        logic         w_r_vld;
        t_ctx         w_r_ctx;
        logic [127:0] w_r_prod;
        logic         r_qe_vld;
        t_ctx         r_qe_ctx;
        logic [63:0]  r_qe;
        logic [63:0]  r_rem;
        logic [63:0]  n_qe;
        logic [63:0]  n_rem;
        logic         r_fin_vld;
        t_ctx         r_fin_ctx;
        t_ctx         n_fin_ctx;

        tanfp_mul u_mul_term (
            .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
            .i_vld  (w_blk_vld[g]), .i_ctx(w_blk_ctx[g]),
            .i_a    (w_blk_ctx[g].term), .i_b(w_blk_ctx[g].u2),
            .o_vld  (w_a_vld), .o_ctx(w_a_ctx), .o_prod(w_a_prod)
        );

        always_comb begin
            n_rd_ctx      = w_a_ctx;
            n_rd_ctx.term = q62_round(w_a_prod);
            n_nm_ctx      = r_rd_ctx;
            n_nm_ctx.aux  = 64'(r_rd_ctx.term * SER_NUM[g]) + 64'(SER_DEN[g] >> 1);
        end

        tanfp_mul u_mul_rcp (
            .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
            .i_vld  (r_nm_vld), .i_ctx(r_nm_ctx),
            .i_a    (r_nm_ctx.aux), .i_b(SER_RCP[g]),
            .o_vld  (w_r_vld), .o_ctx(w_r_ctx), .o_prod(w_r_prod)
        );

        always_comb begin
            n_qe          = w_r_prod[127:64];
            n_rem         = w_r_ctx.aux - 64'(n_qe * 64'(SER_DEN[g]));
            n_fin_ctx     = r_qe_ctx;
            // estimate may be one short of the quotient
            n_fin_ctx.res = r_qe_ctx.res +
                            ((r_rem >= 64'(SER_DEN[g])) ? (r_qe + 64'd1) : r_qe);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rd_vld  <= 1'b0;
                r_nm_vld  <= 1'b0;
                r_qe_vld  <= 1'b0;
                r_fin_vld <= 1'b0;
            end else if (w_adv) begin
                r_rd_vld  <= w_a_vld;
                r_nm_vld  <= r_rd_vld;
                r_qe_vld  <= w_r_vld;
                r_fin_vld <= r_qe_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rd_ctx  <= n_rd_ctx;
                r_nm_ctx  <= n_nm_ctx;
                r_qe_ctx  <= w_r_ctx;
                r_qe      <= n_qe;
                r_rem     <= n_rem;
                r_fin_ctx <= n_fin_ctx;
            end
        end

        assign w_blk_vld[g+1] = r_fin_vld;
        assign w_blk_ctx[g+1] = r_fin_ctx;
    end

    // ---------------- t^2 and 1 - t^2 ----------------
    logic         w_mt_vld;
    t_ctx         w_mt_ctx;
    logic [127:0] w_mt_prod;

    tanfp_mul u_mul_t2 (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_vld  (w_blk_vld[SER_STEPS]), .i_ctx(w_blk_ctx[SER_STEPS]),
        .i_a    (w_blk_ctx[SER_STEPS].res), .i_b(w_blk_ctx[SER_STEPS].res),
        .o_vld  (w_mt_vld), .o_ctx(w_mt_ctx), .o_prod(w_mt_prod)
    );

    logic r_t2_vld;
    t_ctx r_t2_ctx;
    t_ctx n_t2_ctx;

    always_comb begin
        n_t2_ctx     = w_mt_ctx;
        n_t2_ctx.aux = ONE_Q62 - q62_round(w_mt_prod);
    end

    // ---------------- divider setup and one-bit stages ----------------
    logic [DIV_STEPS:0] r_dv_vld;
    t_dvs               r_dv [DIV_STEPS+1];
    t_dvs               n_dv [DIV_STEPS+1];
    logic [63:0]        n_twot;
    logic [63:0]        n_x;
    logic [NW-1:0]      n_np;
    logic [64:0]        n_sh;
    logic               n_ge;

    always_comb begin
        n_twot        = {r_t2_ctx.res[62:0], 1'b0};
        n_x           = r_t2_ctx.odd ? r_t2_ctx.aux : n_twot;
        n_dv[0]       = '0;
        n_dv[0].d     = r_t2_ctx.odd ? n_twot : r_t2_ctx.aux;
        n_np          = {1'b0, n_x, {ANGLE_FRAC_BITS{1'b0}}} + NW'(n_dv[0].d >> 1);
        n_dv[0].neg_res = r_t2_ctx.sr ^ r_t2_ctx.odd ^ r_t2_ctx.neg;
        n_dv[0].odd   = r_t2_ctx.odd;
        n_dv[0].neg   = r_t2_ctx.neg;
        n_dv[0].zero  = (n_dv[0].d == 64'd0);
        // quotient reaches 2^64 when the part above bit 63 already covers d
        n_dv[0].ovf   = (65'(n_np[NW-1:64]) >= {1'b0, n_dv[0].d});
        n_dv[0].rem   = 64'(n_np[NW-1:64]);
        n_dv[0].num   = n_np[63:0];
        n_sh          = '0;
        n_ge          = 1'b0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            n_sh          = {r_dv[j].rem, r_dv[j].num[63]};
            n_ge          = (n_sh >= {1'b0, r_dv[j].d});
            n_dv[j+1]     = r_dv[j];
            n_dv[j+1].rem = n_ge ? 64'(n_sh - {1'b0, r_dv[j].d}) : n_sh[63:0];
            n_dv[j+1].num = {r_dv[j].num[62:0], 1'b0};
            n_dv[j+1].q   = {r_dv[j].q[62:0], n_ge};
        end
    end

    // ---------------- saturation, sign, output ----------------
    logic        r_out_vld;
    logic [63:0] r_tan;
    logic        r_sat;
    logic [63:0] n_tan;
    logic        n_sat;
    logic [63:0] n_lim;
    logic [63:0] n_mag;
    logic        n_nr;

    always_comb begin
        n_nr  = r_dv[DIV_STEPS].neg_res;
        n_lim = n_nr ? SAT_MIN : SAT_MAX;
        n_sat = 1'b1;
        priority if (r_dv[DIV_STEPS].zero) begin
            n_nr  = r_dv[DIV_STEPS].odd ^ r_dv[DIV_STEPS].neg;
            n_mag = n_nr ? SAT_MIN : SAT_MAX;
        end else if (r_dv[DIV_STEPS].ovf || (r_dv[DIV_STEPS].q > n_lim)) begin
            n_mag = n_lim;
        end else begin
            n_mag = r_dv[DIV_STEPS].q;
            n_sat = 1'b0;
        end
        n_tan = n_nr ? (64'd0 - n_mag) : n_mag;
    end

    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s13_vld <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= i_valid;
            r_s4_vld  <= w_m0_vld;
            r_s9_vld  <= w_m2_vld;
            r_s10_vld <= r_s9_vld;
            r_s13_vld <= w_mu_vld;
            r_t2_vld  <= w_mt_vld;
            r_dv_vld  <= {r_dv_vld[DIV_STEPS-1:0], r_t2_vld};
            r_out_vld <= r_dv_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ctx  <= n_s1_ctx;
            r_s4_ctx  <= n_s4_ctx;
            r_s9_ctx  <= w_m2_ctx;
            r_s9_sum  <= n_s9_sum;
            r_s10_ctx <= n_s10_ctx;
            r_s13_ctx <= n_s13_ctx;
            r_t2_ctx  <= n_t2_ctx;
            for (int j = 0; j <= DIV_STEPS; j++) begin
                r_dv[j] <= n_dv[j];
            end
            r_tan <= n_tan;
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_tangent   = $signed(r_tan);
    assign o_saturated = r_sat;

    // a clamped result is always one of the two extremes
    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_sat) |-> ((r_tan == SAT_MAX) || (r_tan == SAT_MIN)))
        else $error("saturated result not at an extreme");

    // a held result freezes the divider valids
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> $stable(r_dv_vld))
        else $error("pipeline moved during stall");

    // an accepted request shows up in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s1_vld)
        else $error("accepted request lost at entry");

endmodule

`default_nettype wire

// ----- sim/tangent_fixed_point_checker.sv -----
`default_nettype none

module tangent_fixed_point_checker import tanfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_angle,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_tangent,
    input  logic        i_saturated,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] tangent;
        logic        saturated;
    } t_tan_result;

    t_tan_result tan_expected_q[$];

    localparam logic [63:0] NUM_TAB [7] = '{64'd1, 64'd1, 64'd2, 64'd17, 64'd62,
                                            64'd1382, 64'd21844};
    localparam logic [63:0] DEN_TAB [7] = '{64'd1, 64'd3, 64'd15, 64'd315, 64'd2835,
                                            64'd155925, 64'd6081075};

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << 61);
        return p[125:62];
    endfunction

    function automatic t_tan_result predict_tangent(input logic [47:0] v);
        logic          neg, odd, sr, negres, sat;
        logic [47:0]   m;
        logic [127:0]  p, kp, red, num, q;
        logic [63:0]   k, lo_hi, a, u, u2, term, res, t, t2, den, d, lim, mag;
        t_tan_result   r;
        neg = v[47];
        m = neg ? (~v + 48'd1) : v;
        p = {80'd0, m} * {64'd0, TWO_OVER_PI};
        k = (p[127:64] + (64'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
        odd = k[0];
        kp = {64'd0, k} * {64'd0, HALF_PI_LO};
        lo_hi = kp[127:64] + {63'd0, kp[63]};
        kp = {64'd0, k} * {64'd0, HALF_PI_HI} + {64'd0, lo_hi};
        red = ({80'd0, m} << (62 - ANGLE_FRAC_BITS)) - kp;
        sr = red[127];
        a = sr ? (64'd0 - red[63:0]) : red[63:0];
        u = a >> 1;
        u2 = mul_q62(u, u);
        term = u;
        res = u;
        for (int i = 1; i < SERIES_TERMS && i < 7; i++) begin
            term = mul_q62(term, u2);
            res = res + (term * NUM_TAB[i] + DEN_TAB[i] / 2) / DEN_TAB[i];
        end
        t = res;
        t2 = mul_q62(t, t);
        den = ONE_Q62 - t2;
        negres = sr ^ odd ^ neg;
        if (odd) begin
            num = {64'd0, den} << ANGLE_FRAC_BITS;
            d = t << 1;
        end else begin
            num = {64'd0, t << 1} << ANGLE_FRAC_BITS;
            d = den;
        end
        lim = negres ? (64'd1 << 63) : ((64'd1 << 63) - 64'd1);
        sat = 1'b0;
        if (d == 64'd0) begin
            // divisor vanished: saturate toward the sign of the pole
            sat = 1'b1;
            negres = odd ^ neg;
            mag = negres ? (64'd1 << 63) : ((64'd1 << 63) - 64'd1);
        end else begin
            q = (num + {64'd0, d >> 1}) / {64'd0, d};
            if (q[127:64] != 64'd0 || q[63:0] > lim) begin
                sat = 1'b1;
                mag = lim;
            end else begin
                mag = q[63:0];
            end
        end
        r.tangent = negres ? (64'd0 - mag) : mag;
        r.saturated = sat;
        return r;
    endfunction

    initial o_errors = 0;
    assign o_pending = tan_expected_q.size();

    always @(posedge i_clk) begin
        t_tan_result exp_r;
        int          n_err;
        n_err = 0;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                tan_expected_q.push_back(predict_tangent(i_angle));
            if (i_out_valid && i_out_ready) begin
                if (tan_expected_q.size() == 0) begin
                    $error("unexpected result: tangent %h saturated %b", i_tangent,
                           i_saturated);
                    n_err = n_err + 1;
                end else begin
                    exp_r = tan_expected_q.pop_front();
                    if (exp_r.tangent !== i_tangent) begin
                        $error("tangent: expected %h actual %h", exp_r.tangent, i_tangent);
                        n_err = n_err + 1;
                    end
                    if (exp_r.saturated !== i_saturated) begin
                        $error("saturated: expected %b actual %b", exp_r.saturated,
                               i_saturated);
                        n_err = n_err + 1;
                    end
                end
            end
        end
        if (n_err != 0)
            o_errors <= o_errors + n_err;
    end

endmodule

`default_nettype wire

// ----- sim/tb_tangent_fixed_point_unit.sv -----
`default_nettype none

module tb_tangent_fixed_point_unit;
    import tanfp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] HALF_PI_FX = 64'd6746518852;  // pi/2 in Q15.32
    localparam int          PHASE_ITEMS = 280;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [47:0] i_angle;
    logic               o_valid;
    logic               i_ready;
    logic signed [63:0] o_tangent;
    logic               o_saturated;
    int                 errors;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    tangent_fixed_point_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_angle     (i_angle),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tangent   (o_tangent),
        .o_saturated (o_saturated)
    );

    tangent_fixed_point_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_angle     (i_angle),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_tangent   (o_tangent),
        .i_saturated (o_saturated),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_angle(input logic [47:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_angle <= x;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // angle near k*pi/2: exercises reduction boundaries and the poles
    function automatic logic [47:0] near_multiple(input int k, input int off);
        logic [63:0] base;
        base = HALF_PI_FX * k + 64'(signed'(off));
        return ($urandom_range(1) != 0) ? base[47:0] : (48'd0 - base[47:0]);
    endfunction

    function automatic logic [47:0] random_angle();
        logic [47:0] x;
        case ($urandom_range(3))
            0: x = 48'({$urandom, $urandom});
            1: x = 48'(signed'($urandom_range(16'hFFFF) - 32768)) <<< 20;
            2: x = near_multiple($urandom_range(20), $urandom_range(2000) - 1000);
            default: x = near_multiple($urandom_range(20000000),
                                       $urandom_range(200) - 100);
        endcase
        return x;
    endfunction

    initial begin
        logic [47:0] directed [$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_angle = '0;
        i_ready = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 56;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{48'd0, 48'd1, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                     48'h8000_0000_0000, 48'h8000_0000_0001, 48'h1_0000_0000,
                     48'hFFFF_0000_0000, 48'h0_C90F_DAA2, 48'hFFFF_36F0_255E,
                     near_multiple(1, 0), near_multiple(1, 1), near_multiple(1, -1),
                     near_multiple(2, 0), near_multiple(3, 0), near_multiple(3, 2),
                     near_multiple(1000, 0), near_multiple(33000000, 0),
                     48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA};
        foreach (directed[i]) send_angle(directed[i]);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 35 : 0;
            repeat (PHASE_ITEMS) send_angle(random_angle());
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
